// ----- rtl/cgi_pkg.sv -----
// ----------------------------------------------------------------------------
// cgi_pkg
// Shared types and constants of the character code to glyph index lookup:
// operation and method codes, field widths and the range descriptor record.
// ----------------------------------------------------------------------------
package cgi_pkg;

  // defaults of the top level parameters
  localparam int MAX_MAPS_DEF   = 8;
  localparam int DATA_DEPTH_DEF = 4096;

  // field widths
  localparam int CODE_W = 16;
  localparam int BASE_W = 12;
  localparam int METH_W = 2;
  localparam int OP_W   = 3;

  // index that means no glyph
  localparam logic [CODE_W-1:0] NO_GLYPH = 16'hFFFF;

  // operation codes
  localparam logic [OP_W-1:0] OP_WR_DESC = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_WORD = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_ALT = 3'd3;
  localparam logic [OP_W-1:0] OP_WR_ALT  = 3'd4;

  // mapping methods
  localparam logic [METH_W-1:0] METH_LINEAR = 2'd0;
  localparam logic [METH_W-1:0] METH_ARRAY  = 2'd1;
  localparam logic [METH_W-1:0] METH_SCAN   = 2'd2;

  // one code range descriptor
  typedef struct packed {
    logic [CODE_W-1:0] first_code;
    logic [CODE_W-1:0] last_code;
    logic [METH_W-1:0] method;
    logic [BASE_W-1:0] base;
  } desc_t;

endpackage

// ----- rtl/cgi_desc_mem.sv -----
// ----------------------------------------------------------------------------
// cgi_desc_mem
// Descriptor store: one write port, one registered read port. Per-slot valid
// bits make an unwritten slot read as an all-zero descriptor after reset.
// ----------------------------------------------------------------------------
module cgi_desc_mem #(
  parameter int MAX_MAPS = cgi_pkg::MAX_MAPS_DEF,
  localparam int SW = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  logic [SW-1:0]  wr_addr,
  input  cgi_pkg::desc_t wr_data,
  input  logic           rd_en,
  input  logic [SW-1:0]  rd_addr,
  output cgi_pkg::desc_t rd_data
);

  cgi_pkg::desc_t      mem [MAX_MAPS];
  logic [MAX_MAPS-1:0] vld_r;
  cgi_pkg::desc_t      q_r;
  logic                q_vld_r;

  // storage array and read data register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // unwritten slot reads as zero
  assign rd_data = q_vld_r ? q_r : '0;

endmodule

// ----- rtl/cgi_word_mem.sv -----
// ----------------------------------------------------------------------------
// cgi_word_mem
// Map data word memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cgi_word_mem #(
  parameter int DATA_DEPTH = cgi_pkg::DATA_DEPTH_DEF,
  localparam int AW = $clog2(DATA_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [cgi_pkg::CODE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [cgi_pkg::CODE_W-1:0] rd_data
);

  logic [cgi_pkg::CODE_W-1:0] mem [DATA_DEPTH];
  logic [cgi_pkg::CODE_W-1:0] q_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule

// ----- rtl/char_code_to_glyph_index.sv -----
// ----------------------------------------------------------------------------
// char_code_to_glyph_index
// Maps a 16-bit character code to a glyph index through a set of code range
// descriptors and a word memory of map data (linear, array or sorted pairs).
// ----------------------------------------------------------------------------
// Usage: write descriptors (operation 0) and map words (operation 1) first,
// then set map_count over the configuration port while the block is idle.
// Write operations (0, 1, 4 and unused codes) finish in the cycle they are
// taken. A lookup or set-alternate examines descriptor slots one per cycle
// through the descriptor memory's read port; a linear or array descriptor
// then reads one map word, and a scan descriptor reads its pair count, then
// makes binary search probes (one per cycle through the word memory's read
// port, at most 12 for a 4095-pair table) and on a match the glyph word.
// The result is held in an output register so the next item is taken while
// it waits. DATA_DEPTH must be a power of two; data addresses wrap on it.
// ----------------------------------------------------------------------------
module char_code_to_glyph_index #(
  parameter int MAX_MAPS   = cgi_pkg::MAX_MAPS_DEF,
  parameter int DATA_DEPTH = cgi_pkg::DATA_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_first_code,
  input  logic [15:0] in_last_code,
  input  logic [1:0]  in_method,
  input  logic [11:0] in_address,
  input  logic [15:0] in_value,
  input  logic [15:0] in_code,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_glyph_index,
  output logic        out_found,
  // map_count register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_map_count
);

  localparam int SW  = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
  localparam int CW  = $clog2(MAX_MAPS + 1);
  localparam int AW  = $clog2(DATA_DEPTH);
  localparam int EAW = 18;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DESC  = 3'd1;
  localparam logic [2:0] S_WORD  = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_PAIR  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // control registers
  logic [2:0]  state_r, state_nxt;
  logic [3:0]  map_count_r;
  logic [15:0] fallback_r, fallback_nxt;
  logic        out_valid_r, out_valid_nxt;

  // payload registers
  logic [2:0]        op_r, op_nxt;
  logic [15:0]       code_r, code_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     slot_r, slot_nxt;
  logic [11:0]       base_r, base_nxt;
  logic [15:0]       off_r, off_nxt;
  logic [1:0]        meth_r, meth_nxt;
  logic signed [16:0] lo_r, lo_nxt;
  logic signed [16:0] hi_r, hi_nxt;
  logic [15:0]       mid_r, mid_nxt;
  logic [15:0]       res_idx_r, res_idx_nxt;
  logic              res_found_r, res_found_nxt;
  logic [15:0]       out_glyph_r, out_glyph_nxt;
  logic              out_found_r, out_found_nxt;

  // memory ports
  logic           desc_wr_en;
  cgi_pkg::desc_t desc_wr_data;
  logic           desc_rd_en;
  logic [SW-1:0]  desc_rd_addr;
  cgi_pkg::desc_t desc_q;
  logic           word_wr_en;
  logic           word_rd_en;
  logic [AW-1:0]  word_rd_addr;
  logic [15:0]    word_q;

  // datapath helpers
  logic           in_accept;
  logic           out_free;
  logic [CW-1:0]  n_eff_c;
  logic [CW-1:0]  slot_inc_c;
  logic           hit_c;
  logic [15:0]    off_c;
  logic [EAW-1:0] dbase_ea_c;
  logic [EAW-1:0] arr_ea_c;
  logic [16:0]    cnt_hi_c;
  logic [15:0]    cnt_mid_c;
  logic [EAW-1:0] cnt_ea_c;
  logic           less_c;
  logic signed [16:0] lo_n_c;
  logic signed [16:0] hi_n_c;
  logic [15:0]    mid_n_c;
  logic [EAW-1:0] nxt_ea_c;
  logic [EAW-1:0] pair_ea_c;
  logic           fin_en;
  logic [15:0]    fin_idx;
  logic           fin_found;

  // handshakes
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // descriptor and word memories
  assign desc_wr_data.first_code = in_first_code;
  assign desc_wr_data.last_code  = in_last_code;
  assign desc_wr_data.method     = in_method;
  assign desc_wr_data.base       = in_address;
  assign desc_wr_en = in_accept && (in_operation == cgi_pkg::OP_WR_DESC) &&
                      (32'(in_slot) < 32'(MAX_MAPS));
  assign word_wr_en = in_accept && (in_operation == cgi_pkg::OP_WR_WORD);

  cgi_desc_mem #(.MAX_MAPS(MAX_MAPS)) u_desc_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (desc_wr_en),
    .wr_addr (SW'(in_slot)),
    .wr_data (desc_wr_data),
    .rd_en   (desc_rd_en),
    .rd_addr (desc_rd_addr),
    .rd_data (desc_q)
  );

  cgi_word_mem #(.DATA_DEPTH(DATA_DEPTH)) u_word_mem (
    .clk     (clk),
    .wr_en   (word_wr_en),
    .wr_addr (AW'(in_address)),
    .wr_data (in_value),
    .rd_en   (word_rd_en),
    .rd_addr (word_rd_addr),
    .rd_data (word_q)
  );

  // slots in use, capped at the descriptor count
  assign n_eff_c    = (32'(map_count_r) > 32'(MAX_MAPS)) ? CW'(MAX_MAPS)
                                                         : CW'(map_count_r);
  assign slot_inc_c = slot_r + CW'(1);

  // descriptor range check and offsets
  assign hit_c      = (desc_q.first_code <= code_r) && (code_r <= desc_q.last_code);
  assign off_c      = code_r - desc_q.first_code;
  assign dbase_ea_c = EAW'(desc_q.base);
  assign arr_ea_c   = EAW'(desc_q.base) + EAW'(off_c);

  // first probe from the pair count
  assign cnt_hi_c  = {1'b0, word_q} - 17'd1;
  assign cnt_mid_c = cnt_hi_c[16:1];
  assign cnt_ea_c  = EAW'(base_r) + EAW'(1) + EAW'({cnt_mid_c, 1'b0});

  // binary search step
  assign less_c    = word_q < code_r;
  assign lo_n_c    = less_c ? ({1'b0, mid_r} + 17'd1) : lo_r;
  assign hi_n_c    = less_c ? hi_r : ({1'b0, mid_r} - 17'd1);
  assign mid_n_c   = 16'((17'(lo_n_c[15:0]) + 17'(hi_n_c[15:0])) >> 1);
  assign nxt_ea_c  = EAW'(base_r) + EAW'(1) + EAW'({mid_n_c, 1'b0});
  assign pair_ea_c = EAW'(base_r) + EAW'(2) + EAW'({mid_r, 1'b0});

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fallback_nxt  = fallback_r;
    op_nxt        = op_r;
    code_nxt      = code_r;
    n_nxt         = n_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    off_nxt       = off_r;
    meth_nxt      = meth_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_idx_nxt   = res_idx_r;
    res_found_nxt = res_found_r;
    desc_rd_en    = 1'b0;
    desc_rd_addr  = '0;
    word_rd_en    = 1'b0;
    word_rd_addr  = '0;
    fin_en        = 1'b0;
    fin_idx       = cgi_pkg::NO_GLYPH;
    fin_found     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_operation)
            cgi_pkg::OP_LOOKUP, cgi_pkg::OP_SET_ALT: begin
              op_nxt   = in_operation;
              code_nxt = in_code;
              n_nxt    = n_eff_c;
              slot_nxt = '0;
              if (n_eff_c == '0) begin
                fin_en = 1'b1;
              end else begin
                desc_rd_en = 1'b1;
                state_nxt  = S_DESC;
              end
            end
            cgi_pkg::OP_WR_ALT: begin
              fallback_nxt = in_value;
            end
            default: begin
            end
          endcase
        end
      end

      S_DESC: begin
        if (hit_c) begin
          base_nxt = desc_q.base;
          off_nxt  = off_c;
          meth_nxt = desc_q.method;
          case (desc_q.method)
            cgi_pkg::METH_LINEAR: begin
              word_rd_en   = 1'b1;
              word_rd_addr = dbase_ea_c[AW-1:0];
              state_nxt    = S_WORD;
            end
            cgi_pkg::METH_ARRAY: begin
              word_rd_en   = 1'b1;
              word_rd_addr = arr_ea_c[AW-1:0];
              state_nxt    = S_WORD;
            end
            cgi_pkg::METH_SCAN: begin
              word_rd_en   = 1'b1;
              word_rd_addr = dbase_ea_c[AW-1:0];
              state_nxt    = S_COUNT;
            end
            default: begin
              fin_en = 1'b1;
            end
          endcase
        end else if (slot_inc_c < n_r) begin
          slot_nxt     = slot_inc_c;
          desc_rd_en   = 1'b1;
          desc_rd_addr = slot_inc_c[SW-1:0];
        end else begin
          fin_en = 1'b1;
        end
      end

      S_WORD: begin
        fin_en  = 1'b1;
        fin_idx = (meth_r == cgi_pkg::METH_LINEAR) ? (word_q + off_r) : word_q;
      end

      S_COUNT: begin
        if (word_q == '0) begin
          fin_en = 1'b1;
        end else begin
          lo_nxt       = '0;
          hi_nxt       = cnt_hi_c;
          mid_nxt      = cnt_mid_c;
          word_rd_en   = 1'b1;
          word_rd_addr = cnt_ea_c[AW-1:0];
          state_nxt    = S_CMP;
        end
      end

      S_CMP: begin
        if (word_q == code_r) begin
          word_rd_en   = 1'b1;
          word_rd_addr = pair_ea_c[AW-1:0];
          state_nxt    = S_PAIR;
        end else if (lo_n_c <= hi_n_c) begin
          lo_nxt       = lo_n_c;
          hi_nxt       = hi_n_c;
          mid_nxt      = mid_n_c;
          word_rd_en   = 1'b1;
          word_rd_addr = nxt_ea_c[AW-1:0];
        end else begin
          fin_en = 1'b1;
        end
      end

      S_PAIR: begin
        fin_en  = 1'b1;
        fin_idx = word_q;
      end

      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // lookup finished: pick index or alternate, update alternate on set
    if (fin_en) begin
      fin_found     = (fin_idx != cgi_pkg::NO_GLYPH);
      res_idx_nxt   = fin_found ? fin_idx : fallback_r;
      res_found_nxt = fin_found;
      if (fin_found && (op_r == cgi_pkg::OP_SET_ALT)) begin
        fallback_nxt = fin_idx;
      end
      state_nxt = S_EMIT;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_glyph_nxt = out_glyph_r;
    out_found_nxt = out_found_r;
    if ((state_r == S_EMIT) && out_free) begin
      out_valid_nxt = 1'b1;
      out_glyph_nxt = res_idx_r;
      out_found_nxt = res_found_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_glyph_index = out_glyph_r;
  assign out_found       = out_found_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      map_count_r <= '0;
      fallback_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fallback_r  <= fallback_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        map_count_r <= cfg_map_count;
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    code_r      <= code_nxt;
    n_r         <= n_nxt;
    slot_r      <= slot_nxt;
    base_r      <= base_nxt;
    off_r       <= off_nxt;
    meth_r      <= meth_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    res_idx_r   <= res_idx_nxt;
    res_found_r <= res_found_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_found_r <= out_found_nxt;
  end

  // a result only appears out of the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit step");

  // write items finish in the cycle they are taken
  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_operation == cgi_pkg::OP_WR_DESC ||
                   in_operation == cgi_pkg::OP_WR_WORD ||
                   in_operation == cgi_pkg::OP_WR_ALT)) |=> (state_r == S_IDLE))
    else $error("write item left sequencer busy");

  // search window never empty while a probe is in flight
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r <= hi_r))
    else $error("binary search probe with empty window");

  // scanned slot stays below the slots in use
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DESC) |-> (slot_r < n_r))
    else $error("descriptor slot beyond map count");

endmodule
